FILE: design/lmts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmts_pkg: LCD mode timing sequencer package
// Mode, operation and register codes, timing constants and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package lmts_pkg;

   // modes (also the STAT mode bits)
   localparam logic [1:0] MODE_HBLANK = 2'd0;
   localparam logic [1:0] MODE_VBLANK = 2'd1;
   localparam logic [1:0] MODE_OAM    = 2'd2;
   localparam logic [1:0] MODE_XFER   = 2'd3;

   // item operations
   localparam logic [1:0] OP_ADVANCE = 2'd0;
   localparam logic [1:0] OP_READ    = 2'd1;
   localparam logic [1:0] OP_WRITE   = 2'd2;

   // register selects
   localparam logic [1:0] REG_LCDC = 2'd0;
   localparam logic [1:0] REG_STAT = 2'd1;
   localparam logic [1:0] REG_LY   = 2'd2;
   localparam logic [1:0] REG_LYC  = 2'd3;

   // mode lengths in clocks
   localparam logic [8:0] OAM_CLOCKS    = 9'd80;
   localparam logic [8:0] XFER_CLOCKS   = 9'd172;
   localparam logic [8:0] HBLANK_CLOCKS = 9'd204;
   localparam logic [8:0] LINE_CLOCKS   = 9'd456;

   localparam logic [7:0] VBLANK_FIRST_LINE = 8'd144;
   localparam logic [7:0] LAST_LINE         = 8'd153;

   localparam logic [7:0] STAT_WRITE_MASK = 8'h78;
   localparam logic [7:0] STAT_KEEP_MASK  = 8'h87;

   // controller to datapath
   typedef struct packed {
      logic start;   // latch the input item
      logic step;    // one mode boundary of an advance
      logic finish;  // last update, load the result register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_adv;    // current item is an advance
      logic adv_done;  // no further mode boundary inside the item
   } status_type;

endpackage
`default_nettype wire

FILE: design/lcd_mode_timing_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcd_mode_timing_sequencer: LCD mode timing sequencer
// An item is latched on entry, then steps once per mode boundary crossed
// by an advance, and finally loads the result register once the output
// register is free. The mode boundary loop in the controller does the
// stepping. The next item is taken while a result still waits in the
// output register.
// ----------------------------------------------------------------------------
module lcd_mode_timing_sequencer
   import lmts_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_op,
   input  wire logic [1:0] req_reg_select,
   input  wire logic [7:0] req_write_value,
   input  wire logic [7:0] req_clocks,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_read_data,
   output logic [1:0]      rsp_mode,
   output logic [7:0]      rsp_line_counter,
   output logic            rsp_stat_irq,
   output logic            rsp_vblank_irq,
   output logic            rsp_oam_locked,
   output logic            rsp_vram_locked,
   output logic            rsp_frame_pulse,
   output logic            rsp_frame_ready
);

   cmd_type    cmd;
   status_type st;

   lmts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .st        (st),
      .cmd       (cmd)
   );

   lmts_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .st               (st),
      .req_op           (req_op),
      .req_reg_select   (req_reg_select),
      .req_write_value  (req_write_value),
      .req_clocks       (req_clocks),
      .rsp_read_data    (rsp_read_data),
      .rsp_mode         (rsp_mode),
      .rsp_line_counter (rsp_line_counter),
      .rsp_stat_irq     (rsp_stat_irq),
      .rsp_vblank_irq   (rsp_vblank_irq),
      .rsp_oam_locked   (rsp_oam_locked),
      .rsp_vram_locked  (rsp_vram_locked),
      .rsp_frame_pulse  (rsp_frame_pulse),
      .rsp_frame_ready  (rsp_frame_ready)
   );

endmodule
`default_nettype wire

FILE: design/lmts_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmts_ctrl: sequencer controller
// Accepts an item, steps the datapath across mode boundaries and hands the
// result to the output register once it is free.
// ----------------------------------------------------------------------------
module lmts_ctrl
   import lmts_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   input  wire status_type st,
   output cmd_type         cmd
);

   typedef enum logic {
      IDLE,
      RUN
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = RUN;
            end
         end
         RUN: begin
            if (st.is_adv && !st.adv_done) begin
               cmd.step = 1'b1;
            end else if (out_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_finish_after_steps: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!st.is_adv || st.adv_done))
      else $error("result loaded with mode boundaries pending");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !cmd.finish)
      else $error("result register overwritten while held");

   a_finish_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("finished item not presented");

   a_accept_runs: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == RUN && !req_ready))
      else $error("accepted transfer not processed");

endmodule
`default_nettype wire

FILE: design/lmts_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmts_dp: sequencer datapath
// Mode/line/LY state, the four registers, per-item request flags and the
// result register.
// ----------------------------------------------------------------------------
module lmts_dp
   import lmts_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cmd_type    cmd,
   output status_type      st,
   input  wire logic [1:0] req_op,
   input  wire logic [1:0] req_reg_select,
   input  wire logic [7:0] req_write_value,
   input  wire logic [7:0] req_clocks,
   output logic [7:0]      rsp_read_data,
   output logic [1:0]      rsp_mode,
   output logic [7:0]      rsp_line_counter,
   output logic            rsp_stat_irq,
   output logic            rsp_vblank_irq,
   output logic            rsp_oam_locked,
   output logic            rsp_vram_locked,
   output logic            rsp_frame_pulse,
   output logic            rsp_frame_ready
);

   // display state
   logic [1:0] mode_ff, mode_in;
   logic [8:0] left_ff, left_in;
   logic [7:0] line_ff, line_in;
   logic [7:0] ly_ff, ly_in;
   logic [7:0] lyc_ff, lyc_in;
   logic [7:0] lcdc_ff, lcdc_in;
   logic [7:0] stat_ff, stat_in;
   logic       oam_ff, oam_in;
   logic       vram_ff, vram_in;
   logic       rdy_ff, rdy_in;

   // current item
   logic [1:0] op_ff, op_in;
   logic [1:0] sel_ff, sel_in;
   logic [7:0] val_ff, val_in;
   logic [7:0] n_ff, n_in;
   logic       irq_stat_ff, irq_stat_in;
   logic       irq_vb_ff, irq_vb_in;
   logic       pulse_ff, pulse_in;

   // result register
   logic [7:0] out_rd_ff;
   logic [1:0] out_mode_ff;
   logic [7:0] out_ly_ff;
   logic       out_stat_ff, out_vb_ff, out_oam_ff, out_vram_ff;
   logic       out_pulse_ff, out_rdy_ff;

   logic       ent;
   logic [1:0] ent_mode;
   logic       ly_set;
   logic [7:0] ly_val;
   logic [7:0] rd;
   logic       n_below;

   assign n_below     = ({1'b0, n_ff} < left_ff);
   assign st.is_adv   = (op_ff == OP_ADVANCE);
   assign st.adv_done = !lcdc_ff[7] || n_below;

   always_comb begin
      mode_in     = mode_ff;
      left_in     = left_ff;
      line_in     = line_ff;
      ly_in       = ly_ff;
      lyc_in      = lyc_ff;
      lcdc_in     = lcdc_ff;
      stat_in     = stat_ff;
      oam_in      = oam_ff;
      vram_in     = vram_ff;
      rdy_in      = rdy_ff;
      op_in       = op_ff;
      sel_in      = sel_ff;
      val_in      = val_ff;
      n_in        = n_ff;
      irq_stat_in = irq_stat_ff;
      irq_vb_in   = irq_vb_ff;
      pulse_in    = pulse_ff;
      ent         = 1'b0;
      ent_mode    = MODE_OAM;
      ly_set      = 1'b0;
      ly_val      = ly_ff;
      rd          = 8'd0;

      if (cmd.start) begin
         op_in       = req_op;
         sel_in      = req_reg_select;
         val_in      = req_write_value;
         n_in        = req_clocks;
         irq_stat_in = 1'b0;
         irq_vb_in   = 1'b0;
         pulse_in    = 1'b0;
      end

      if (cmd.step) begin
         n_in = n_ff - left_ff[7:0];
         case (mode_ff)
            MODE_OAM: begin
               ent      = 1'b1;
               ent_mode = MODE_XFER;
            end
            MODE_XFER: begin
               ent      = 1'b1;
               ent_mode = MODE_HBLANK;
            end
            MODE_HBLANK: begin
               line_in  = line_ff + 8'd1;
               ly_set   = 1'b1;
               ly_val   = ly_ff + 8'd1;
               ent      = 1'b1;
               ent_mode = (line_in != VBLANK_FIRST_LINE) ? MODE_OAM : MODE_VBLANK;
            end
            default: begin
               if (line_ff == LAST_LINE) begin
                  line_in  = 8'd0;
                  ent      = 1'b1;
                  ent_mode = MODE_OAM;
                  ly_set   = 1'b1;
                  ly_val   = 8'd0;
               end else begin
                  left_in = LINE_CLOCKS;
                  line_in = line_ff + 8'd1;
                  ly_set  = 1'b1;
                  ly_val  = ly_ff + 8'd1;
               end
            end
         endcase
      end

      if (cmd.finish) begin
         case (op_ff)
            OP_ADVANCE: begin
               if (lcdc_ff[7] && n_below) begin
                  left_in = left_ff - {1'b0, n_ff};
               end
            end
            OP_READ: begin
               case (sel_ff)
                  REG_LCDC: rd = lcdc_ff;
                  REG_STAT: rd = stat_ff;
                  REG_LY:   rd = ly_ff;
                  default:  rd = lyc_ff;
               endcase
            end
            OP_WRITE: begin
               case (sel_ff)
                  REG_LCDC: begin
                     if (lcdc_ff[7] != val_ff[7]) begin
                        if (!val_ff[7]) begin
                           vram_in  = 1'b0;
                           oam_in   = 1'b0;
                           rdy_in   = 1'b1;
                           pulse_in = 1'b1;
                        end else begin
                           line_in  = 8'd0;
                           ent      = 1'b1;
                           ent_mode = MODE_OAM;
                           ly_set   = 1'b1;
                           ly_val   = 8'd0;
                        end
                     end
                     lcdc_in = val_ff;
                  end
                  REG_STAT: stat_in = (stat_ff & STAT_KEEP_MASK) | (val_ff & STAT_WRITE_MASK);
                  REG_LY: begin
                     ly_set = 1'b1;
                     ly_val = val_ff;
                  end
                  default: lyc_in = val_ff;
               endcase
            end
            default: ;
         endcase
      end

      if (ent) begin
         mode_in      = ent_mode;
         stat_in[1:0] = ent_mode;
         case (ent_mode)
            MODE_HBLANK: begin
               oam_in  = 1'b0;
               vram_in = 1'b0;
               left_in = HBLANK_CLOCKS;
               rdy_in  = 1'b0;
               if (stat_ff[3]) irq_stat_in = 1'b1;
            end
            MODE_VBLANK: begin
               oam_in    = 1'b0;
               vram_in   = 1'b0;
               left_in   = LINE_CLOCKS;
               rdy_in    = 1'b1;
               pulse_in  = 1'b1;
               irq_vb_in = 1'b1;
               if (stat_ff[4]) irq_stat_in = 1'b1;
            end
            MODE_OAM: begin
               oam_in  = 1'b1;
               vram_in = 1'b0;
               left_in = OAM_CLOCKS;
               rdy_in  = 1'b0;
               if (stat_ff[5]) irq_stat_in = 1'b1;
            end
            default: begin
               oam_in  = 1'b1;
               vram_in = 1'b1;
               left_in = XFER_CLOCKS;
               rdy_in  = 1'b0;
            end
         endcase
      end

      if (ly_set) begin
         ly_in      = ly_val;
         stat_in[2] = (ly_val == lyc_ff);
         if ((ly_val == lyc_ff) && stat_ff[6]) irq_stat_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_OAM;
         left_ff     <= OAM_CLOCKS;
         line_ff     <= 8'd0;
         ly_ff       <= 8'd0;
         lyc_ff      <= 8'd0;
         lcdc_ff     <= 8'd0;
         stat_ff     <= 8'h06;
         oam_ff      <= 1'b1;
         vram_ff     <= 1'b0;
         rdy_ff      <= 1'b0;
         irq_stat_ff <= 1'b0;
         irq_vb_ff   <= 1'b0;
         pulse_ff    <= 1'b0;
      end else begin
         mode_ff     <= mode_in;
         left_ff     <= left_in;
         line_ff     <= line_in;
         ly_ff       <= ly_in;
         lyc_ff      <= lyc_in;
         lcdc_ff     <= lcdc_in;
         stat_ff     <= stat_in;
         oam_ff      <= oam_in;
         vram_ff     <= vram_in;
         rdy_ff      <= rdy_in;
         irq_stat_ff <= irq_stat_in;
         irq_vb_ff   <= irq_vb_in;
         pulse_ff    <= pulse_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      sel_ff <= sel_in;
      val_ff <= val_in;
      n_ff   <= n_in;
      if (cmd.finish) begin
         out_rd_ff    <= rd;
         out_mode_ff  <= mode_in;
         out_ly_ff    <= ly_in;
         out_stat_ff  <= irq_stat_in;
         out_vb_ff    <= irq_vb_in;
         out_oam_ff   <= oam_in;
         out_vram_ff  <= vram_in;
         out_pulse_ff <= pulse_in;
         out_rdy_ff   <= rdy_in;
      end
   end

   assign rsp_read_data    = out_rd_ff;
   assign rsp_mode         = out_mode_ff;
   assign rsp_line_counter = out_ly_ff;
   assign rsp_stat_irq     = out_stat_ff;
   assign rsp_vblank_irq   = out_vb_ff;
   assign rsp_oam_locked   = out_oam_ff;
   assign rsp_vram_locked  = out_vram_ff;
   assign rsp_frame_pulse  = out_pulse_ff;
   assign rsp_frame_ready  = out_rdy_ff;

endmodule
`default_nettype wire

FILE: sim/lmts_result_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmts_result_check: result checker for the LCD mode timing sequencer
// Watches both channels, keeps its own copy of the mode timing state,
// predicts one status record per accepted request and compares every
// accepted response with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module lmts_result_check
   import lmts_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [1:0] req_op,
   input  logic [1:0] req_reg_select,
   input  logic [7:0] req_write_value,
   input  logic [7:0] req_clocks,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_read_data,
   input  logic [1:0] rsp_mode,
   input  logic [7:0] rsp_line_counter,
   input  logic       rsp_stat_irq,
   input  logic       rsp_vblank_irq,
   input  logic       rsp_oam_locked,
   input  logic       rsp_vram_locked,
   input  logic       rsp_frame_pulse,
   input  logic       rsp_frame_ready,
   output int         fail_count,
   output int         pending,
   output int         status_seen,
   output int         frames_seen,
   output int         vblank_seen,
   output int         stat_irq_seen
);

   typedef struct packed {
      logic [7:0] read_data;
      logic [1:0] mode;
      logic [7:0] line_counter;
      logic       stat_irq;
      logic       vblank_irq;
      logic       oam_locked;
      logic       vram_locked;
      logic       frame_pulse;
      logic       frame_ready;
   } status_rec_type;

   status_rec_type status_q[$];
   status_rec_type want;
   status_rec_type got;

   // shadow of the sequencer state
   logic [1:0]  lcd_mode;
   logic [8:0]  mode_left;
   logic [7:0]  scan_line;
   logic [7:0]  ly;
   logic [7:0]  lyc;
   logic [7:0]  lcdc;
   logic [7:0]  stat;
   logic        oam_lock;
   logic        vram_lock;
   logic        frame_flag;
   logic        hit_stat;
   logic        hit_vblank;
   logic        hit_frame;

   task automatic clear_shadow();
      lcd_mode   = MODE_OAM;
      mode_left  = OAM_CLOCKS;
      scan_line  = 8'd0;
      ly         = 8'd0;
      lyc        = 8'd0;
      lcdc       = 8'd0;
      stat       = 8'h06;
      oam_lock   = 1'b1;
      vram_lock  = 1'b0;
      frame_flag = 1'b0;
   endtask

   task automatic enter_mode(input logic [1:0] m);
      lcd_mode = m;
      stat[1:0] = m;
      case (m)
         MODE_HBLANK: begin
            oam_lock = 1'b0; vram_lock = 1'b0; mode_left = HBLANK_CLOCKS; frame_flag = 1'b0;
            if (stat[3]) hit_stat = 1'b1;
         end
         MODE_VBLANK: begin
            oam_lock = 1'b0; vram_lock = 1'b0; mode_left = LINE_CLOCKS; frame_flag = 1'b1;
            hit_frame = 1'b1;
            hit_vblank = 1'b1;
            if (stat[4]) hit_stat = 1'b1;
         end
         MODE_OAM: begin
            oam_lock = 1'b1; vram_lock = 1'b0; mode_left = OAM_CLOCKS; frame_flag = 1'b0;
            if (stat[5]) hit_stat = 1'b1;
         end
         default: begin
            oam_lock = 1'b1; vram_lock = 1'b1; mode_left = XFER_CLOCKS; frame_flag = 1'b0;
         end
      endcase
   endtask

   task automatic load_ly(input logic [7:0] v);
      ly = v;
      stat[2] = (ly == lyc);
      if (stat[2] && stat[6]) hit_stat = 1'b1;
   endtask

   task automatic run_clocks(input logic [8:0] n);
      if (!lcdc[7]) return;
      while (n != 9'd0) begin
         if (n < mode_left) begin
            mode_left = mode_left - n;
            n = 9'd0;
         end else begin
            n = n - mode_left;
            case (lcd_mode)
               MODE_OAM:  enter_mode(MODE_XFER);
               MODE_XFER: enter_mode(MODE_HBLANK);
               MODE_HBLANK: begin
                  scan_line = scan_line + 8'd1;
                  load_ly(ly + 8'd1);
                  enter_mode(scan_line != VBLANK_FIRST_LINE ? MODE_OAM : MODE_VBLANK);
               end
               default: begin
                  if (scan_line == LAST_LINE) begin
                     frame_flag = 1'b0;
                     scan_line = 8'd0;
                     enter_mode(MODE_OAM);
                     load_ly(8'd0);
                  end else begin
                     mode_left = LINE_CLOCKS;
                     scan_line = scan_line + 8'd1;
                     load_ly(ly + 8'd1);
                  end
               end
            endcase
         end
      end
   endtask

   task automatic write_lcdc(input logic [7:0] v);
      if (lcdc[7] != v[7]) begin
         if (!v[7]) begin
            vram_lock = 1'b0;
            oam_lock = 1'b0;
            frame_flag = 1'b1;
            hit_frame = 1'b1;
         end else begin
            scan_line = 8'd0;
            enter_mode(MODE_OAM);
            load_ly(8'd0);
         end
      end
      lcdc = v;
   endtask

   task automatic predict_status(input logic [1:0] op, input logic [1:0] sel,
                                 input logic [7:0] val, input logic [7:0] clk,
                                 output status_rec_type rec);
      logic [7:0] rd;
      rd = 8'd0;
      hit_stat = 1'b0;
      hit_vblank = 1'b0;
      hit_frame = 1'b0;
      case (op)
         OP_ADVANCE: run_clocks({1'b0, clk});
         OP_READ: begin
            case (sel)
               REG_LCDC: rd = lcdc;
               REG_STAT: rd = stat;
               REG_LY:   rd = ly;
               default:  rd = lyc;
            endcase
         end
         OP_WRITE: begin
            case (sel)
               REG_LCDC: write_lcdc(val);
               REG_STAT: stat = (stat & STAT_KEEP_MASK) | (val & STAT_WRITE_MASK);
               REG_LY:   load_ly(val);
               default:  lyc = val;
            endcase
         end
         default: ;
      endcase
      rec.read_data    = rd;
      rec.mode         = lcd_mode;
      rec.line_counter = ly;
      rec.stat_irq     = hit_stat;
      rec.vblank_irq   = hit_vblank;
      rec.oam_locked   = oam_lock;
      rec.vram_locked  = vram_lock;
      rec.frame_pulse  = hit_frame;
      rec.frame_ready  = frame_flag;
   endtask

   task automatic check_field(input string name, input logic [7:0] exp_v,
                              input logic [7:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected 0x%02h, actual 0x%02h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
      status_seen = 0;
      frames_seen = 0;
      vblank_seen = 0;
      stat_irq_seen = 0;
      clear_shadow();
   end

   always @(posedge clock) begin
      if (reset) begin
         clear_shadow();
         status_q.delete();
         pending = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.read_data    = rsp_read_data;
            got.mode         = rsp_mode;
            got.line_counter = rsp_line_counter;
            got.stat_irq     = rsp_stat_irq;
            got.vblank_irq   = rsp_vblank_irq;
            got.oam_locked   = rsp_oam_locked;
            got.vram_locked  = rsp_vram_locked;
            got.frame_pulse  = rsp_frame_pulse;
            got.frame_ready  = rsp_frame_ready;
            if (status_q.size() == 0) begin
               $error("response transfer with no request outstanding");
               fail_count++;
            end else begin
               want = status_q.pop_front();
               check_field("read_data", want.read_data, got.read_data);
               check_field("mode", {6'd0, want.mode}, {6'd0, got.mode});
               check_field("line_counter", want.line_counter, got.line_counter);
               check_field("stat_irq", {7'd0, want.stat_irq}, {7'd0, got.stat_irq});
               check_field("vblank_irq", {7'd0, want.vblank_irq}, {7'd0, got.vblank_irq});
               check_field("oam_locked", {7'd0, want.oam_locked}, {7'd0, got.oam_locked});
               check_field("vram_locked", {7'd0, want.vram_locked},
                           {7'd0, got.vram_locked});
               check_field("frame_pulse", {7'd0, want.frame_pulse},
                           {7'd0, got.frame_pulse});
               check_field("frame_ready", {7'd0, want.frame_ready},
                           {7'd0, got.frame_ready});
            end
            status_seen++;
            if (got.frame_pulse) frames_seen++;
            if (got.vblank_irq) vblank_seen++;
            if (got.stat_irq) stat_irq_seen++;
         end
         if (req_valid && req_ready) begin
            predict_status(req_op, req_reg_select, req_write_value, req_clocks, want);
            status_q.push_back(want);
         end
         pending = status_q.size();
      end
   end

endmodule

FILE: sim/tb_lcd_mode_timing_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lcd_mode_timing_sequencer: testbench for the LCD mode timing sequencer
// Drives a directed run through display on/off, register access and mode
// boundaries, then random traffic biased toward long clock advances so that
// whole frames run, under four handshake idling profiles, the first with a long
// response hold-off. Checking is done by lmts_result_check.
// ----------------------------------------------------------------------------
module tb_lcd_mode_timing_sequencer;
   import lmts_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_PER_PHASE = 200;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [1:0] req_op;
   logic [1:0] req_reg_select;
   logic [7:0] req_write_value;
   logic [7:0] req_clocks;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_read_data;
   logic [1:0] rsp_mode;
   logic [7:0] rsp_line_counter;
   logic       rsp_stat_irq;
   logic       rsp_vblank_irq;
   logic       rsp_oam_locked;
   logic       rsp_vram_locked;
   logic       rsp_frame_pulse;
   logic       rsp_frame_ready;

   int fail_count;
   int pending;
   int status_seen;
   int frames_seen;
   int vblank_seen;
   int stat_irq_seen;

   int send_idle_pct;
   int rsp_stall_pct;
   int hold_left;

   lcd_mode_timing_sequencer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_reg_select   (req_reg_select),
      .req_write_value  (req_write_value),
      .req_clocks       (req_clocks),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_data    (rsp_read_data),
      .rsp_mode         (rsp_mode),
      .rsp_line_counter (rsp_line_counter),
      .rsp_stat_irq     (rsp_stat_irq),
      .rsp_vblank_irq   (rsp_vblank_irq),
      .rsp_oam_locked   (rsp_oam_locked),
      .rsp_vram_locked  (rsp_vram_locked),
      .rsp_frame_pulse  (rsp_frame_pulse),
      .rsp_frame_ready  (rsp_frame_ready)
   );

   lmts_result_check u_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_reg_select   (req_reg_select),
      .req_write_value  (req_write_value),
      .req_clocks       (req_clocks),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_data    (rsp_read_data),
      .rsp_mode         (rsp_mode),
      .rsp_line_counter (rsp_line_counter),
      .rsp_stat_irq     (rsp_stat_irq),
      .rsp_vblank_irq   (rsp_vblank_irq),
      .rsp_oam_locked   (rsp_oam_locked),
      .rsp_vram_locked  (rsp_vram_locked),
      .rsp_frame_pulse  (rsp_frame_pulse),
      .rsp_frame_ready  (rsp_frame_ready),
      .fail_count       (fail_count),
      .pending          (pending),
      .status_seen      (status_seen),
      .frames_seen      (frames_seen),
      .vblank_seen      (vblank_seen),
      .stat_irq_seen    (stat_irq_seen)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("lcd_mode_timing_sequencer verification failed");
      $finish;
   end

   // response side: random stall, or a long hold-off when requested
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   task automatic send_req(input logic [1:0] op, input logic [1:0] sel,
                           input logic [7:0] val, input logic [7:0] clk);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= op;
      req_reg_select  <= sel;
      req_write_value <= val;
      req_clocks      <= clk;
      do @(posedge clock); while (!req_ready);
   endtask

   // lower valid and wait until every outstanding status has come back
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic send_random();
      int unsigned pick;
      int unsigned span;
      logic [1:0]  sel;
      logic [7:0]  val;
      pick = $urandom_range(99);
      span = $urandom_range(99);
      sel = 2'($urandom_range(3));
      val = 8'($urandom_range(255));
      if (pick < 72) begin
         if (span < 55) val = 8'd255;
         else if (span >= 85) val = 8'($urandom_range(7));
         send_req(OP_ADVANCE, sel, 8'($urandom_range(255)), val);
      end else if (pick < 82) begin
         send_req(OP_READ, sel, val, 8'($urandom_range(255)));
      end else if (pick < 97) begin
         if (sel == REG_LCDC && span < 92) val[7] = 1'b1;
         if (sel == REG_LYC && span < 70) val = 8'($urandom_range(153));
         send_req(OP_WRITE, sel, val, 8'($urandom_range(255)));
      end else begin
         send_req(OP_UNUSED, sel, val, 8'($urandom_range(255)));
      end
   endtask

   initial begin
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_op          <= OP_ADVANCE;
      req_reg_select  <= REG_LCDC;
      req_write_value <= 8'd0;
      req_clocks      <= 8'd0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_left = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: reset values, display off, turn on, mode edges, LY write, turn off and on, unused op
      send_req(OP_READ, REG_LCDC, 8'h00, 8'h00);
      send_req(OP_READ, REG_STAT, 8'h00, 8'h00);
      send_req(OP_READ, REG_LY, 8'h00, 8'h00);
      send_req(OP_READ, REG_LYC, 8'h00, 8'h00);
      send_req(OP_ADVANCE, REG_LCDC, 8'h00, 8'd255);
      send_req(OP_WRITE, REG_STAT, 8'hFF, 8'h00);
      send_req(OP_WRITE, REG_LYC, 8'h00, 8'h00);
      send_req(OP_WRITE, REG_LCDC, 8'h91, 8'h00);
      send_req(OP_ADVANCE, REG_LCDC, 8'h00, 8'd0);
      send_req(OP_ADVANCE, REG_LCDC, 8'h00, 8'd79);
      send_req(OP_ADVANCE, REG_LCDC, 8'h00, 8'd1);
      send_req(OP_ADVANCE, REG_LCDC, 8'h00, 8'd255);
      send_req(OP_ADVANCE, REG_LCDC, 8'h00, 8'd255);
      send_req(OP_WRITE, REG_LY, 8'hFF, 8'h00);
      send_req(OP_ADVANCE, REG_LCDC, 8'h00, 8'd255);
      send_req(OP_WRITE, REG_LYC, 8'h55, 8'h00);
      send_req(OP_WRITE, REG_LCDC, 8'h11, 8'h00);
      send_req(OP_ADVANCE, REG_LCDC, 8'h00, 8'd200);
      send_req(OP_WRITE, REG_LCDC, 8'h80, 8'h00);
      send_req(OP_WRITE, REG_LCDC, 8'h80, 8'h00);
      send_req(OP_UNUSED, REG_LYC, 8'hFF, 8'hFF);
      send_req(OP_READ, REG_STAT, 8'hFF, 8'hFF);
      send_req(OP_READ, REG_LY, 8'h00, 8'h00);
      send_req(OP_WRITE, REG_STAT, 8'h00, 8'h00);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 82; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 82; end
            default: begin send_idle_pct = 10; rsp_stall_pct = 10; end
         endcase
         // long response hold-off while requests keep coming
         if (phase == 0) hold_left = 150;
         for (int i = 0; i < RANDOM_PER_PHASE; i++) send_random();
         drain();
      end

      repeat (10) @(posedge clock);
      $display("Run covered %0d status transfers over four handshake profiles,", status_seen);
      $display("with %0d frame pulses, %0d vblank and %0d STAT requests observed.",
               frames_seen, vblank_seen, stat_irq_seen);
      if (fail_count == 0 && pending == 0) begin
         $display("lcd_mode_timing_sequencer verification clean");
      end else begin
         $display("lcd_mode_timing_sequencer verification failed");
      end
      $finish;
   end

endmodule
